/* hw/rtl/mdp_pkg.sv */
// Shared types, constants and helpers for the modular dot product block.
`default_nettype none

package mdp_pkg;

   localparam int ElemWidth  = 32;
   localparam int ModWidth   = 31;
   localparam int CountWidth = $clog2(ElemWidth);

   localparam logic [ModWidth-1:0]   ModulusReset = {ModWidth{1'b1}};
   localparam logic [CountWidth-1:0] CountLast    = CountWidth'(ElemWidth - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_FIX,
      ST_SUM,
      ST_DONE
   } mdp_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } mdp_ctrl_type;

   // Maps a residue r of a magnitude back to the residue of the signed value.
   function automatic logic [ModWidth-1:0] mdp_negate_mod(input logic [ModWidth-1:0] p,
                                                          input logic [ModWidth-1:0] r,
                                                          input logic neg);
      mdp_negate_mod = (neg && (r != '0)) ? (p - r) : r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/mdp_reduce_lane.sv */
// Bit-serial restoring reduction of a 32-bit magnitude modulo p.
`default_nettype none

module mdp_reduce_lane import mdp_pkg::*; (
   input  wire logic                  clock,
   input  wire mdp_ctrl_type          ctrl,
   input  wire logic [ElemWidth-1:0]  load_value,
   input  wire logic [ModWidth-1:0]   modulus,
   output logic      [ModWidth-1:0]   remainder
);

   logic [ElemWidth-1:0] shift_ff, shift_in;
   logic [ModWidth-1:0]  rem_ff, rem_in;
   logic [ModWidth:0]    trial;
   logic [ModWidth:0]    diff;

   always_comb begin
      // One dividend bit enters per cycle while step is asserted; the remainder stays below p.
      trial    = {rem_ff, shift_ff[ElemWidth-1]};
      diff     = trial - {1'b0, modulus};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (ctrl.load) begin
         shift_in = load_value;
         rem_in   = '0;
      end else if (ctrl.step) begin
         shift_in = {shift_ff[ElemWidth-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, modulus}) ? diff[ModWidth-1:0] : trial[ModWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hw/rtl/mdp_mulmod.sv */
// Bit-serial modular multiplier, most significant multiplier bit first.
`default_nettype none

module mdp_mulmod import mdp_pkg::*; (
   input  wire logic                  clock,
   input  wire mdp_ctrl_type          ctrl,
   input  wire logic [ElemWidth-1:0]  load_value,
   input  wire logic [ModWidth-1:0]   multiplicand,
   input  wire logic [ModWidth-1:0]   modulus,
   output logic      [ModWidth-1:0]   product
);

   logic [ElemWidth-1:0] shift_ff, shift_in;
   logic [ModWidth-1:0]  acc_ff, acc_in;
   logic [ModWidth+1:0]  dbl;
   logic [ModWidth+1:0]  addend;
   logic [ModWidth+1:0]  total;
   logic [ModWidth+2:0]  less_one;
   logic [ModWidth+2:0]  less_two;

   always_comb begin
      // acc = 2*acc + bit*multiplicand lies below 3p, so at most 2p comes off.
      dbl      = {1'b0, acc_ff, 1'b0};
      addend   = shift_ff[ElemWidth-1] ? {2'b00, multiplicand} : '0;
      total    = dbl + addend;
      less_one = {1'b0, total} - {3'b000, modulus};
      less_two = {1'b0, total} - {2'b00, modulus, 1'b0};
      shift_in = shift_ff;
      acc_in   = acc_ff;
      if (ctrl.load) begin
         shift_in = load_value;
         acc_in   = '0;
      end else if (ctrl.step) begin
         shift_in = {shift_ff[ElemWidth-2:0], 1'b0};
         if (!less_two[ModWidth+2]) begin
            acc_in = less_two[ModWidth-1:0];
         end else if (!less_one[ModWidth+2]) begin
            acc_in = less_one[ModWidth-1:0];
         end else begin
            acc_in = total[ModWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign product = acc_ff;

endmodule

`default_nettype wire

/* hw/rtl/modular_dot_product.sv */
// Top level of the modular dot product with symmetric residue output.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_elem_a, req_elem_b, req_last_pair
//   rsp      out        rsp_valid/rsp_ready    rsp_dot_residue
//   csr      in         csr_wr_en              csr_wr_data (modulus)
//
// A beat is accepted only in ST_IDLE: after acceptance two bit-serial lanes reduce
// |elem_b| and |running sum| mod p, then the bit-serial modular multiplier runs over
// |elem_a|, then come the fix-up states ST_FIX, ST_SUM and ST_DONE; req_ready
// returns in the cycle after ST_DONE, so a new beat waits until the last is through.
// Reset is synchronous: it sets the modulus to 2^31-1 and clears the running sum.
// A last beat waits in its final cycle while an earlier result is not yet taken.
`default_nettype none

module modular_dot_product import mdp_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [ElemWidth-1:0] req_elem_a,
   input  wire logic signed [ElemWidth-1:0] req_elem_b,
   input  wire logic                        req_last_pair,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [ModWidth-1:0]       rsp_dot_residue,
   input  wire logic                        csr_wr_en,
   input  wire logic [ModWidth-1:0]         csr_wr_data
);

   mdp_state_type            state_ff, state_in;
   logic [CountWidth-1:0]    cnt_ff, cnt_in;
   logic [ModWidth-1:0]      modulus_ff;
   logic [ModWidth-1:0]      p_eff;
   logic                     last_ff, last_in;
   logic                     prod_neg_ff, prod_neg_in;
   logic                     rs_neg_ff, rs_neg_in;
   logic [ElemWidth-1:0]     running_sum_ff, running_sum_in;
   logic [ModWidth-1:0]      m_ff, m_in;
   logic [ModWidth-1:0]      rsm_ff, rsm_in;
   logic [ModWidth-1:0]      sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ModWidth-1:0]      rsp_data_ff, rsp_data_in;

   logic [ElemWidth-1:0]     a_bits, b_bits;
   logic [ElemWidth-1:0]     a_mag, b_mag, rs_mag;
   logic [ModWidth-1:0]      b_rem, rs_rem, prod_rem;
   logic [ModWidth:0]        pair_sum;
   logic [ElemWidth-1:0]     sym;
   mdp_ctrl_type             lane_ctrl, mul_ctrl;

   assign p_eff  = (modulus_ff < ModWidth'(2)) ? ModWidth'(1) : modulus_ff;
   assign a_bits = req_elem_a;
   assign b_bits = req_elem_b;
   assign a_mag  = a_bits[ElemWidth-1] ? (~a_bits + ElemWidth'(1)) : a_bits;
   assign b_mag  = b_bits[ElemWidth-1] ? (~b_bits + ElemWidth'(1)) : b_bits;
   assign rs_mag = running_sum_ff[ElemWidth-1] ? (~running_sum_ff + ElemWidth'(1))
                                               : running_sum_ff;

   mdp_reduce_lane u_b_lane (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .load_value (b_mag),
      .modulus    (p_eff),
      .remainder  (b_rem)
   );

   mdp_reduce_lane u_rs_lane (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .load_value (rs_mag),
      .modulus    (p_eff),
      .remainder  (rs_rem)
   );

   mdp_mulmod u_mulmod (
      .clock        (clock),
      .ctrl         (mul_ctrl),
      .load_value   (a_mag),
      .multiplicand (b_rem),
      .modulus      (p_eff),
      .product      (prod_rem)
   );

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      last_in        = last_ff;
      prod_neg_in    = prod_neg_ff;
      rs_neg_in      = rs_neg_ff;
      running_sum_in = running_sum_ff;
      m_in           = m_ff;
      rsm_in         = rsm_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      req_ready      = 1'b0;
      lane_ctrl      = '0;
      mul_ctrl       = '0;
      pair_sum       = {1'b0, m_ff} + {1'b0, rsm_ff};
      // Symmetric range: values above p/2 move down by p (two's complement wrap).
      sym            = ({sum_ff, 1'b0} > {1'b0, p_eff})
                       ? ({1'b0, sum_ff} - {1'b0, p_eff}) : {1'b0, sum_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               lane_ctrl.load = 1'b1;
               mul_ctrl.load  = 1'b1;
               last_in        = req_last_pair;
               prod_neg_in    = a_bits[ElemWidth-1] ^ b_bits[ElemWidth-1];
               rs_neg_in      = running_sum_ff[ElemWidth-1];
               cnt_in         = '0;
               state_in       = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            lane_ctrl.step = 1'b1;
            cnt_in         = cnt_ff + CountWidth'(1);
            if (cnt_ff == CountLast) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            mul_ctrl.step = 1'b1;
            cnt_in        = cnt_ff + CountWidth'(1);
            if (cnt_ff == CountLast) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            m_in     = mdp_negate_mod(p_eff, prod_rem, prod_neg_ff);
            rsm_in   = mdp_negate_mod(p_eff, rs_rem, rs_neg_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = (pair_sum >= {1'b0, p_eff})
                       ? ModWidth'(pair_sum - {1'b0, p_eff}) : pair_sum[ModWidth-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (last_ff) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in   = 1'b1;
                  rsp_data_in    = sym[ModWidth-1:0];
                  running_sum_in = '0;
                  state_in       = ST_IDLE;
               end
            end else begin
               running_sum_in = sym;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         modulus_ff     <= ModulusReset;
         running_sum_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         running_sum_ff <= running_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      prod_neg_ff <= prod_neg_in;
      rs_neg_ff   <= rs_neg_in;
      m_ff        <= m_in;
      rsm_ff      <= rsm_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dot_residue = rsp_data_ff;

   // Both lane remainders must be proper residues once the multiplier uses them.
   a_lane_residue : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> ((b_rem < p_eff) && (rs_rem < p_eff)))
      else $error("reduction lane remainder not below modulus");

   // The folded sum must be fully reduced before the symmetric step.
   a_sum_reduced : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (sum_ff < p_eff))
      else $error("sum not reduced below modulus");

   // A new result only comes from the final cycle of a beat marked last.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_ff && (state_ff == ST_DONE)))
      else $error("result raised without a last beat");

endmodule

`default_nettype wire
